// ===== rtl/core/dws_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and slot arithmetic for the deque with search unit
package dws_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 5;
    localparam int OCC_W       = 5;
    localparam int STAT_W      = 2;
    localparam int ACT_W       = 3;

    localparam logic [POS_W-1:0] POS_NONE = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_COUNT      = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // one access to the entry memory
    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]       raddr;
    } ram_req_t;

    // slot of the entry k places behind the front, k below CAPACITY
    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] front,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(front) + (CNT_W+1)'(k);
        if (s >= (CNT_W+1)'(CAPACITY))
        begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s == IDX_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s == '0)
        begin
            r = IDX_W'(CAPACITY - 1);
        end
        else
        begin
            r = s - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/dws_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces of the deque with search unit
interface dws_req_if;
    logic                                valid;
    logic                                ready;
    logic [dws_pkg::ACT_W-1:0]           action;
    logic signed [dws_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dws_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [dws_pkg::STAT_W-1:0]             status;
    logic signed [dws_pkg::POS_W-1:0]       position;
    logic [dws_pkg::OCC_W-1:0]              occupancy;
    logic signed [dws_pkg::VALUE_WIDTH-1:0] popped_value;

    modport source (output valid, output status, output position, output occupancy,
                    output popped_value, input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    input popped_value, output ready);
endinterface

// ===== rtl/core/dws_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dws_ctrl.sv =====
`timescale 1ns / 1ps
// request sequencer: ring pointers, pop read-back, search scan and result register
module dws_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    dws_req_if.sink                          req,
    dws_rsp_if.source                        rsp,
    output dws_pkg::ram_req_t                ram_req,
    input  logic [dws_pkg::VALUE_WIDTH-1:0]  ram_rdata
);

    import dws_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       front_reg, front_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;

    status_t                res_status_reg, res_status_next;
    logic [POS_W-1:0]       res_pos_reg, res_pos_next;
    logic [VALUE_WIDTH-1:0] res_popped_reg, res_popped_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic [OCC_W-1:0]       out_occ_reg, out_occ_next;
    logic [VALUE_WIDTH-1:0] out_popped_reg, out_popped_next;

    logic                   full;
    logic                   empty;
    logic [CNT_W-1:0]       scan_ahead;

    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign scan_ahead = CNT_W'(scan_reg) + CNT_W'(1);

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.position     = out_pos_reg;
    assign rsp.occupancy    = out_occ_reg;
    assign rsp.popped_value = out_popped_reg;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_popped_next = res_popped_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_occ_next    = out_occ_reg;
        out_popped_next = out_popped_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = front_reg;
        ram_req.wdata = VALUE_WIDTH'(req.value);
        ram_req.raddr = front_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = STAT_DONE;
                    res_pos_next    = POS_NONE;
                    res_popped_next = '0;
                    state_next      = ST_DONE;
                    unique case (req.action)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = slot_before(front_reg);
                                front_next    = slot_before(front_reg);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = slot_at(front_reg, count_reg);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_req.raddr = front_reg;
                                front_next    = slot_after(front_reg);
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = ST_POP;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_req.raddr = slot_at(front_reg, count_reg - CNT_W'(1));
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = ST_POP;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            key_next = VALUE_WIDTH'(req.value);
                            if (!empty)
                            begin
                                ram_req.raddr = front_reg;
                                scan_next     = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // count and unused codes only report the occupancy
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                res_popped_next = ram_rdata;
                state_next      = ST_DONE;
            end
            ST_SCAN:
            begin
                // fetch the next entry while the current one is compared
                ram_req.raddr = slot_at(front_reg, scan_ahead);
                if (ram_rdata == key_reg)
                begin
                    res_pos_next = POS_W'(scan_reg);
                    state_next   = ST_DONE;
                end
                else if (scan_ahead == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next = scan_ahead[IDX_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_occ_next    = OCC_W'(count_reg);
                    out_popped_next = res_popped_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_popped_reg <= res_popped_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_occ_reg    <= out_occ_next;
        out_popped_reg <= out_popped_next;
    end

endmodule

// ===== rtl/core/deque_with_search_unit.sv =====
`timescale 1ns / 1ps
// top level of the deque with search unit
// A bounded double-ended queue of signed 32-bit values, kept as a ring buffer
// of 16 entries in one synchronous memory. Each request item on req (push
// front, push back, pop front, pop back, search, count) gives exactly one
// response item on rsp with status, search position, occupancy after the
// request and the popped value. Requests are taken one at a time: a push, a
// count, an empty search or any rejected request goes from acceptance to the
// done state and back to idle, a pop passes the pop state for the registered
// memory read, and a search scans up to the hit or the last stored entry,
// since the scan compares one stored entry per cycle through the single
// memory read port. The response sits in an output register, so a new
// request is accepted while the previous response waits on rsp.ready; the
// block only stalls when a second response is ready before the first left.
// No clearing pass runs after reset: entries are only used once written.
module deque_with_search_unit (
    input  logic      clk,
    input  logic      rst_n,
    dws_req_if.sink   req,
    dws_rsp_if.source rsp
);

    import dws_pkg::*;

    ram_req_t               ram_req;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // pointers, sequencing and the response register
    dws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // ring storage, one write and one registered read per cycle
    dws_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/dws_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the deque with search unit and their bind
module dws_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [dws_pkg::STAT_W-1:0]        status,
    input logic [dws_pkg::POS_W-1:0]         position,
    input logic [dws_pkg::OCC_W-1:0]         occupancy,
    input logic [dws_pkg::VALUE_WIDTH-1:0]   popped_value
);

    import dws_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position)
            && $stable(occupancy) && $stable(popped_value))
        else $error("response changed while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_FULL |-> occupancy == OCC_W'(CAPACITY)
            && position == POS_NONE)
        else $error("full reported below capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_EMPTY |-> occupancy == '0 && popped_value == '0)
        else $error("empty reported with entries or data");

    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && position != POS_NONE |-> position < occupancy
            && status == STAT_DONE)
        else $error("search hit outside stored entries");

endmodule

bind deque_with_search_unit dws_checker u_dws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .position     (rsp.position),
    .occupancy    (rsp.occupancy),
    .popped_value (rsp.popped_value)
);
